### rtl/kocnt_pkg.sv
// Package with the sizes, control types and helper functions of the key occurrence counter.
package kocnt_pkg;

	localparam int ENTRIES    = 64;
	localparam int KEY_BYTES  = 16;
	localparam int COUNT_BITS = 32;
	localparam int KEY_BITS   = 8 * KEY_BYTES;
	localparam int DIST_W     = $clog2(ENTRIES + 1);
	localparam int OUT_CNT_W  = 32;
	localparam int OUT_DIST_W = 7;

	typedef logic [KEY_BITS-1:0]   key_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [DIST_W-1:0]     dist_t;

	typedef enum logic {
		OP_ADD    = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_UPDATE = 2'b10
	} state_t;

	typedef struct packed {
		logic cmp_en;
		logic upd_en;
		logic alloc;
	} cell_ctrl_t;

	function automatic count_t count_inc(input count_t c);
		return (c == '1) ? c : c + count_t'(1);
	endfunction

	function automatic logic [OUT_CNT_W-1:0] count_out(input count_t c);
		logic [63:0] w;
		w = 64'(c);
		return (w > 64'(32'hFFFF_FFFF)) ? '1 : w[OUT_CNT_W-1:0];
	endfunction

	function automatic logic [OUT_DIST_W-1:0] dist_out(input dist_t d);
		logic [63:0] w;
		w = 64'(d);
		return (w > 64'(127)) ? '1 : w[OUT_DIST_W-1:0];
	endfunction

endpackage

### rtl/key_occurrence_counter_top.sv
// Top level of the key occurrence counter: control, chain of entry cells and result register.
//
// Usage: an input beat carries an operation (add or lookup) and a 128-bit key split
// into key_high and key_low. Every input beat yields exactly one result beat with
// found, key_count, table_full, distinct_keys and total_adds.
// The accept edge compares the key against every entry cell in parallel; the update step
// then applies the add (count increment or claim of the first free cell, which each
// cell detects from its left neighbor's valid flag) and loads the result register.
// The block takes no new beat until the previous update is done, since each compare needs
// the table state left by the previous update. When the result register is full and
// the receiver stalls, the update step waits and in_stall stays high until the result
// can be loaded.
// Reset empties the table, clears both totals and leaves no result pending; the block
// accepts a beat in the first cycle after reset is released.
module key_occurrence_counter_top import kocnt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  operation,
	input  logic [63:0]           key_high,
	input  logic [63:0]           key_low,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  found,
	output logic [OUT_CNT_W-1:0]  key_count,
	output logic                  table_full,
	output logic [OUT_DIST_W-1:0] distinct_keys,
	output logic [OUT_CNT_W-1:0]  total_adds
);

	state_t     state_q;
	logic       op_add_s1;
	key_t       key_s1;
	key_t       key_in;
	logic [127:0] key_full;
	dist_t      distinct_q;
	logic [OUT_CNT_W-1:0] adds_q;
	logic       out_valid_q;

	logic       in_acc;
	logic       out_free;
	logic       finish;
	cell_ctrl_t ctrl;

	logic [ENTRIES-1:0] cell_valid;
	logic [ENTRIES-1:0] cell_match;
	count_t             cell_count [ENTRIES];
	logic [ENTRIES:0]   chain_valid;

	logic   hit_any;
	count_t sel_count;
	logic   tbl_full;
	logic   do_alloc;
	logic   do_count;

	assign key_full = {key_high, key_low};
	assign key_in   = key_full[KEY_BITS-1:0];

	assign out_free = ~out_valid_q | ~out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid & ~in_stall;
	assign finish   = (state_q == ST_UPDATE) & out_free;

	always_comb begin
		sel_count = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			sel_count = sel_count | (cell_count[i] & {COUNT_BITS{cell_match[i]}});
		end
	end

	assign hit_any  = |cell_match;
	assign tbl_full = chain_valid[ENTRIES];
	assign do_alloc = finish & op_add_s1 & ~hit_any & ~tbl_full;
	assign do_count = op_add_s1 & (hit_any | ~tbl_full);

	assign ctrl = '{cmp_en: in_acc, upd_en: finish & op_add_s1, alloc: do_alloc};

	assign chain_valid[0] = 1'b1;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		kocnt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.key_cmp    (key_in),
			.key_wr     (key_s1),
			.prev_valid (chain_valid[g]),
			.valid      (cell_valid[g]),
			.match      (cell_match[g]),
			.count      (cell_count[g])
		);
		assign chain_valid[g+1] = cell_valid[g];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			distinct_q  <= '0;
			adds_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (do_alloc) begin
				distinct_q <= distinct_q + dist_t'(1);
			end
			if (finish && do_count && (adds_q != '1)) begin
				adds_q <= adds_q + OUT_CNT_W'(1);
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_add_s1 <= (operation == OP_ADD);
			key_s1    <= key_in;
		end
		if (finish) begin
			found      <= hit_any;
			table_full <= op_add_s1 & ~hit_any & tbl_full;
			if (hit_any) begin
				key_count <= op_add_s1 ? count_out(count_inc(sel_count)) : count_out(sel_count);
			end else if (op_add_s1 && !tbl_full) begin
				key_count <= OUT_CNT_W'(1);
			end else begin
				key_count <= '0;
			end
			distinct_keys <= dist_out(do_alloc ? distinct_q + dist_t'(1) : distinct_q);
			total_adds    <= (do_count && (adds_q != '1)) ? adds_q + OUT_CNT_W'(1) : adds_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/kocnt_cell.sv
// One table entry: stored key, occurrence count, valid flag and registered match.
module kocnt_cell import kocnt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  key_t       key_cmp,
	input  key_t       key_wr,
	input  logic       prev_valid,
	output logic       valid,
	output logic       match,
	output count_t     count
);

	logic   valid_q;
	logic   match_q;
	key_t   key_q;
	count_t count_q;
	logic   claim;

	assign claim = ctrl.alloc & ~valid_q & prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctrl.cmp_en) begin
				match_q <= valid_q & (key_q == key_cmp);
			end
			if (claim) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (claim) begin
			key_q   <= key_wr;
			count_q <= count_t'(1);
		end else if (ctrl.upd_en && match_q) begin
			count_q <= count_inc(count_q);
		end
	end

	assign valid = valid_q;
	assign match = match_q;
	assign count = count_q;

endmodule

### rtl/kocnt_checker.sv
// Port-level checker for the key occurrence counter, bound to the top level.
module kocnt_checker import kocnt_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic                  found,
	input logic [OUT_CNT_W-1:0]  key_count,
	input logic                  table_full,
	input logic [OUT_DIST_W-1:0] distinct_keys
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	a_one_per_two: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input beat accepted in back-to-back cycles");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> !found && key_count == '0 &&
			distinct_keys == dist_out(dist_t'(ENTRIES)))
		else $error("dropped add reported with inconsistent fields");

	a_found_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> key_count != '0 && !table_full)
		else $error("present key reported with zero count");

endmodule

bind key_occurrence_counter_top kocnt_checker u_kocnt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.found         (found),
	.key_count     (key_count),
	.table_full    (table_full),
	.distinct_keys (distinct_keys)
);
